// ===== sv/npe_pkg.sv =====
// Shared constants, types and saturation helpers for the NURBS evaluator.
package npe_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DEGREE     = 3;
    localparam int FRAC_BITS  = 16;
    localparam int KNOT_SLOTS = MAX_POINTS + DEGREE + 1;

    localparam int IDX_W    = 7;
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 24;
    localparam int KNOT_W   = 17;
    localparam int GAIN_W   = 24;
    localparam int PADDR_W  = $clog2(MAX_POINTS);
    localparam int KADDR_W  = $clog2(KNOT_SLOTS);

    // working precision of the de Boor datapath
    localparam int ACC_W     = 64;
    localparam int MUL_B_W   = 33;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);
    localparam int DIV_D_W   = 25;
    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    localparam int JW  = $clog2(DEGREE + 1);
    localparam int KNW = $clog2(2 * DEGREE);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(28018);
    localparam logic signed [ACC_W-1:0] HLIM = (ACC_W'(1) <<< (62 - FRAC_BITS)) - ACC_W'(1);

    localparam logic [1:0] OP_WR_POINT = 2'd0;
    localparam logic [1:0] OP_WR_KNOT  = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;
    localparam logic [1:0] OP_START    = 2'd3;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_INDEX = 2'd1;
    localparam logic [1:0] STS_ZERO_DIV  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [WEIGHT_W-1:0]       w;
    } point_t;

    typedef struct packed {
        logic                      start;
        logic signed [ACC_W-1:0]   a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [ACC_W-1:0] num;
        logic [DIV_D_W-1:0]      den;
    } div_req_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
        lo = -(ACC_W'(1) <<< (COORD_W - 1));
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp_hlim(input logic signed [ACC_W-1:0] v);
        if (v > HLIM) begin
            return HLIM;
        end else if (v < -HLIM) begin
            return -HLIM;
        end
        return v;
    endfunction

endpackage

// ===== sv/npe_store.sv =====
// Control point and knot memories, one write and one registered read each.
module npe_store (
    input  logic                    aclk,
    input  logic                    point_we,
    input  logic [npe_pkg::PADDR_W-1:0] point_waddr,
    input  npe_pkg::point_t         point_wdata,
    input  logic [npe_pkg::PADDR_W-1:0] point_raddr,
    output npe_pkg::point_t         point_rdata,
    input  logic                    knot_we,
    input  logic [npe_pkg::KADDR_W-1:0] knot_waddr,
    input  logic [npe_pkg::KNOT_W-1:0]  knot_wdata,
    input  logic [npe_pkg::KADDR_W-1:0] knot_raddr,
    output logic [npe_pkg::KNOT_W-1:0]  knot_rdata
);
    import npe_pkg::*;

    point_t            point_mem [MAX_POINTS];
    logic [KNOT_W-1:0] knot_mem  [KNOT_SLOTS];
    point_t            point_rd_reg;
    logic [KNOT_W-1:0] knot_rd_reg;

    always_ff @(posedge aclk) begin
        if (point_we) begin
            point_mem[point_waddr] <= point_wdata;
        end
        point_rd_reg <= point_mem[point_raddr];
    end

    always_ff @(posedge aclk) begin
        if (knot_we) begin
            knot_mem[knot_waddr] <= knot_wdata;
        end
        knot_rd_reg <= knot_mem[knot_raddr];
    end

    assign point_rdata = point_rd_reg;
    assign knot_rdata  = knot_rd_reg;

endmodule

// ===== sv/npe_mul.sv =====
// Shift-and-add multiplier: signed 64-bit by signed 33-bit, one bit per cycle.
module npe_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  npe_pkg::mul_req_t             req,
    output logic                          done,
    output logic signed [npe_pkg::ACC_W-1:0] prod
);
    import npe_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [MUL_CNT_W-1:0]    cnt_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_reg;
    logic [MUL_B_W-2:0]      mag_reg;
    logic                    neg_reg;
    logic [MUL_B_W-1:0]      b_abs;

    assign b_abs = req.b[MUL_B_W-1] ? MUL_B_W'(-req.b) : MUL_B_W'(req.b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                a_reg    <= req.a;
                mag_reg  <= b_abs[MUL_B_W-2:0];
                neg_reg  <= req.b[MUL_B_W-1];
                acc_reg  <= '0;
                cnt_reg  <= MUL_CNT_W'(MUL_B_W - 1);
            end else if (busy_reg) begin
                if (mag_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= a_reg <<< 1;
                mag_reg <= mag_reg >> 1;
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? -acc_reg : acc_reg;

endmodule

// ===== sv/npe_div.sv =====
// Restoring divider: signed 64-bit by unsigned 25-bit, truncating toward zero.
module npe_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  npe_pkg::div_req_t             req,
    output logic                          done,
    output logic signed [npe_pkg::ACC_W-1:0] quo
);
    import npe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0]     q_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic                 neg_reg;
    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     rem_sub;
    logic                 fits;

    always_comb begin
        rem_sh  = {rem_reg, q_reg[ACC_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                q_reg    <= req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
                neg_reg  <= req.num[ACC_W-1];
                den_reg  <= req.den;
                rem_reg  <= '0;
                cnt_reg  <= DIV_CNT_W'(ACC_W);
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
                q_reg   <= {q_reg[ACC_W-2:0], fits};
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

// ===== sv/nurbs_point_and_tangent_eval.sv =====
// Top level: rational cubic NURBS point/tangent sequencer with tool integrator.
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    opcode, index, coord_x/y, point_weight, param_value
//  m_        out  m_valid/m_ready    curve_x/y, slope_x/y, tool_x/y, status
//  gain      in   step_gain_we       step_gain_wdata (Q0.24, no read-back)
//
// One item at a time. An evaluate runs all its arithmetic through one shared
// 64-step divider and one 32-step multiplier, one operation after another.
// Reset (aresetn low, synchronous) clears the sequencer, output valid and tool
// position and reloads the default gain; the point and knot memories keep
// whatever they held.
// A result waiting on m_ready holds the sequencer in its last state only after
// the next item's work is done; s_ready is high whenever the sequencer is idle.
module nurbs_point_and_tangent_eval (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_opcode,
    input  logic [npe_pkg::IDX_W-1:0]         s_index,
    input  logic signed [npe_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [npe_pkg::COORD_W-1:0] s_coord_y,
    input  logic [npe_pkg::WEIGHT_W-1:0]      s_point_weight,
    input  logic [npe_pkg::KNOT_W-1:0]        s_param_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [npe_pkg::COORD_W-1:0] m_curve_x,
    output logic signed [npe_pkg::COORD_W-1:0] m_curve_y,
    output logic signed [npe_pkg::COORD_W-1:0] m_slope_x,
    output logic signed [npe_pkg::COORD_W-1:0] m_slope_y,
    output logic signed [npe_pkg::COORD_W-1:0] m_tool_x,
    output logic signed [npe_pkg::COORD_W-1:0] m_tool_y,
    output logic [1:0]                        m_status,
    input  logic                              step_gain_we,
    input  logic [npe_pkg::GAIN_W-1:0]        step_gain_wdata
);
    import npe_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_KRD   = 5'd1;
    localparam logic [4:0] S_KWT   = 5'd2;
    localparam logic [4:0] S_KCHK  = 5'd3;
    localparam logic [4:0] S_PRD   = 5'd4;
    localparam logic [4:0] S_PWT   = 5'd5;
    localparam logic [4:0] S_PMUL  = 5'd6;
    localparam logic [4:0] S_DIFF  = 5'd7;
    localparam logic [4:0] S_RAT   = 5'd8;
    localparam logic [4:0] S_BLEND = 5'd9;
    localparam logic [4:0] S_ADV   = 5'd10;
    localparam logic [4:0] S_FCHK  = 5'd11;
    localparam logic [4:0] S_FDIV  = 5'd12;
    localparam logic [4:0] S_FMUL  = 5'd13;
    localparam logic [4:0] S_FSDIV = 5'd14;
    localparam logic [4:0] S_GMUL  = 5'd15;
    localparam logic [4:0] S_RD0   = 5'd16;
    localparam logic [4:0] S_ST0   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    // sequencer control
    logic [4:0]         state_reg;
    logic               wait_reg;
    logic [KNW-1:0]     c_reg;
    logic [JW-1:0]      j_reg;
    logic [JW-1:0]      k_reg;
    logic [1:0]         comp_reg;
    logic               phase_reg;
    logic [1:0]         status_reg;

    // item and working values
    logic [IDX_W-1:0]        e_reg;
    logic [KNOT_W-1:0]       u_reg;
    logic [KNOT_W-1:0]       t_reg;
    logic [KNOT_W-1:0]       kn_reg [2*DEGREE];
    point_t                  pt_reg;
    logic signed [ACC_W-1:0] h_reg [3][DEGREE+1];
    logic signed [ACC_W-1:0] d_reg [3][DEGREE+1];
    logic signed [ACC_W-1:0] tmp_reg;
    logic signed [COORD_W-1:0] r_reg [2];
    logic signed [COORD_W-1:0] slope_reg [2];
    logic signed [COORD_W-1:0] pos_reg [2];
    logic [GAIN_W-1:0]       gain_reg;

    // result register
    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_curve_x_reg;
    logic signed [COORD_W-1:0] m_curve_y_reg;
    logic signed [COORD_W-1:0] m_slope_x_reg;
    logic signed [COORD_W-1:0] m_slope_y_reg;
    logic signed [COORD_W-1:0] m_tool_x_reg;
    logic signed [COORD_W-1:0] m_tool_y_reg;
    logic [1:0]                m_status_reg;

    // memory and unit connections
    logic               s_accept;
    logic               point_we;
    logic               knot_we;
    logic [PADDR_W-1:0] point_raddr;
    logic [KADDR_W-1:0] knot_raddr;
    point_t             point_wdata;
    point_t             point_rdata;
    logic [KNOT_W-1:0]  knot_rdata;
    mul_req_t           mul_req;
    div_req_t           div_req;
    logic               mul_done;
    logic               div_done;
    logic signed [ACC_W-1:0] mul_prod;
    logic signed [ACC_W-1:0] div_quo;

    // combinational helpers
    logic [KNW-1:0]            kn_lo_idx;
    logic [KNW-1:0]            kn_hi_idx;
    logic signed [KNOT_W+1:0]  kden;
    logic signed [KNOT_W+1:0]  udiff;
    logic signed [KNOT_W+1:0]  unum;
    logic [JW-1:0]             j_prev;
    logic signed [ACC_W-1:0]   a_prev;
    logic signed [ACC_W-1:0]   a_cur;
    logic signed [ACC_W-1:0]   blend_val;
    logic signed [ACC_W-1:0]   w_val;
    logic signed [COORD_W-1:0] dwc;
    logic [JW-1:0]             j_low;
    logic [JW-1:0]             k_max;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign point_we    = s_accept && (s_opcode == OP_WR_POINT) && (s_index < MAX_POINTS);
    assign knot_we     = s_accept && (s_opcode == OP_WR_KNOT) && (s_index < KNOT_SLOTS);
    assign point_wdata = '{x: s_coord_x, y: s_coord_y, w: s_point_weight};

    npe_store u_store (
        .aclk        (aclk),
        .point_we    (point_we),
        .point_waddr (s_index[PADDR_W-1:0]),
        .point_wdata (point_wdata),
        .point_raddr (point_raddr),
        .point_rdata (point_rdata),
        .knot_we     (knot_we),
        .knot_waddr  (s_index[KADDR_W-1:0]),
        .knot_wdata  (s_param_value),
        .knot_raddr  (knot_raddr),
        .knot_rdata  (knot_rdata)
    );

    npe_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    npe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Operand selection for the memories and the shared units.
    always_comb begin
        j_prev     = j_reg - JW'(1);
        j_low      = k_reg + JW'(1) - JW'(phase_reg);
        k_max      = JW'(DEGREE - 1) + JW'(phase_reg);
        kn_lo_idx  = KNW'(j_prev);
        kn_hi_idx  = KNW'(j_prev) + KNW'(DEGREE);
        if (state_reg == S_RAT) begin
            kn_hi_idx = KNW'(j_prev) + KNW'(DEGREE) + KNW'(phase_reg) - KNW'(k_reg);
        end
        kden  = $signed({2'b00, kn_reg[kn_hi_idx]}) - $signed({2'b00, kn_reg[kn_lo_idx]});
        udiff = $signed({2'b00, u_reg}) - $signed({2'b00, kn_reg[kn_lo_idx]});
        if (udiff < 0) begin
            unum = '0;
        end else if (udiff > kden) begin
            unum = kden;
        end else begin
            unum = udiff;
        end
        a_prev    = phase_reg ? h_reg[comp_reg][j_prev] : d_reg[comp_reg][j_prev];
        a_cur     = phase_reg ? h_reg[comp_reg][j_reg] : d_reg[comp_reg][j_reg];
        blend_val = ((a_prev <<< FRAC_BITS) + mul_prod) >>> FRAC_BITS;
        w_val     = h_reg[2][DEGREE];
        dwc       = sat32(d_reg[2][DEGREE]);

        mul_req     = '0;
        div_req     = '0;
        point_raddr = '0;
        knot_raddr  = '0;
        unique case (state_reg)
            S_KRD: begin
                knot_raddr = KADDR_W'(e_reg) + KADDR_W'(c_reg) - KADDR_W'(DEGREE - 1);
            end
            S_PRD: begin
                point_raddr = PADDR_W'(e_reg) + PADDR_W'(c_reg) - PADDR_W'(DEGREE);
            end
            S_PMUL: begin
                mul_req.start = !wait_reg;
                mul_req.a     = comp_reg[0] ? ACC_W'(pt_reg.y) : ACC_W'(pt_reg.x);
                mul_req.b     = MUL_B_W'(pt_reg.w);
            end
            S_DIFF: begin
                div_req.start = !wait_reg && (kden > 0);
                div_req.num   = ((h_reg[comp_reg][j_reg] - h_reg[comp_reg][j_prev])
                                 * ACC_W'(DEGREE)) <<< FRAC_BITS;
                div_req.den   = DIV_D_W'(kden[KNOT_W-1:0]);
            end
            S_RAT: begin
                div_req.start = !wait_reg && (kden > 0);
                div_req.num   = ACC_W'(unum) <<< FRAC_BITS;
                div_req.den   = DIV_D_W'(kden[KNOT_W-1:0]);
            end
            S_BLEND: begin
                mul_req.start = !wait_reg;
                mul_req.a     = a_cur - a_prev;
                mul_req.b     = MUL_B_W'(t_reg);
            end
            S_FDIV: begin
                div_req.start = !wait_reg;
                div_req.num   = h_reg[comp_reg][DEGREE] <<< FRAC_BITS;
                div_req.den   = w_val[DIV_D_W-1:0];
            end
            S_FMUL: begin
                mul_req.start = !wait_reg;
                mul_req.a     = ACC_W'(dwc);
                mul_req.b     = MUL_B_W'(r_reg[comp_reg[0]]);
            end
            S_FSDIV: begin
                div_req.start = !wait_reg;
                div_req.num   = clamp_hlim(d_reg[comp_reg][DEGREE] - (tmp_reg >>> FRAC_BITS))
                                <<< FRAC_BITS;
                div_req.den   = w_val[DIV_D_W-1:0];
            end
            S_GMUL: begin
                mul_req.start = !wait_reg;
                mul_req.a     = ACC_W'(slope_reg[comp_reg[0]]);
                mul_req.b     = MUL_B_W'(gain_reg);
            end
            S_RD0: begin
                point_raddr = '0;
            end
            default: begin
            end
        endcase
    end

    // Sequencer and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            pos_reg[0]  <= '0;
            pos_reg[1]  <= '0;
            gain_reg    <= GAIN_RESET;
        end else begin
            if (step_gain_we) begin
                gain_reg <= step_gain_wdata;
            end
            if (mul_req.start || div_req.start) begin
                wait_reg <= 1'b1;
            end
            // drop a taken item; S_OUT reloads the register on its own
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        e_reg        <= s_index;
                        u_reg        <= s_param_value;
                        c_reg        <= '0;
                        r_reg[0]     <= '0;
                        r_reg[1]     <= '0;
                        slope_reg[0] <= '0;
                        slope_reg[1] <= '0;
                        unique case (s_opcode)
                            OP_WR_POINT: begin
                                status_reg <= (s_index >= MAX_POINTS) ? STS_BAD_INDEX
                                                                      : STS_OK;
                                state_reg  <= S_OUT;
                            end
                            OP_WR_KNOT: begin
                                status_reg <= (s_index >= KNOT_SLOTS) ? STS_BAD_INDEX
                                                                      : STS_OK;
                                state_reg  <= S_OUT;
                            end
                            OP_EVAL: begin
                                if (s_index < DEGREE || s_index >= MAX_POINTS) begin
                                    status_reg <= STS_BAD_INDEX;
                                    state_reg  <= S_OUT;
                                end else begin
                                    status_reg <= STS_OK;
                                    state_reg  <= S_KRD;
                                end
                            end
                            OP_START: begin
                                status_reg <= STS_OK;
                                state_reg  <= S_RD0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // load knot[e-p+1] .. knot[e+p]
                S_KRD: begin
                    state_reg <= S_KWT;
                end
                S_KWT: begin
                    kn_reg[c_reg] <= knot_rdata;
                    if (c_reg == KNW'(2 * DEGREE - 1)) begin
                        state_reg <= S_KCHK;
                    end else begin
                        c_reg     <= c_reg + KNW'(1);
                        state_reg <= S_KRD;
                    end
                end
                // empty span, then clamp u into it
                S_KCHK: begin
                    c_reg <= '0;
                    if (kn_reg[DEGREE] <= kn_reg[DEGREE-1]) begin
                        status_reg <= STS_BAD_INDEX;
                        state_reg  <= S_OUT;
                    end else begin
                        if (u_reg < kn_reg[DEGREE-1]) begin
                            u_reg <= kn_reg[DEGREE-1];
                        end else if (u_reg > kn_reg[DEGREE]) begin
                            u_reg <= kn_reg[DEGREE];
                        end
                        state_reg <= S_PRD;
                    end
                end
                // weighted points of the span
                S_PRD: begin
                    state_reg <= S_PWT;
                end
                S_PWT: begin
                    pt_reg    <= point_rdata;
                    comp_reg  <= 2'd0;
                    state_reg <= S_PMUL;
                end
                S_PMUL: begin
                    if (mul_done) begin
                        wait_reg <= 1'b0;
                        h_reg[comp_reg][c_reg[JW-1:0]] <= mul_prod >>> FRAC_BITS;
                        if (comp_reg == 2'd0) begin
                            comp_reg <= 2'd1;
                        end else begin
                            h_reg[2][c_reg[JW-1:0]] <= ACC_W'(pt_reg.w);
                            comp_reg <= 2'd0;
                            if (c_reg == KNW'(DEGREE)) begin
                                j_reg     <= JW'(1);
                                state_reg <= S_DIFF;
                            end else begin
                                c_reg     <= c_reg + KNW'(1);
                                state_reg <= S_PRD;
                            end
                        end
                    end
                end
                // first differences scaled by degree over knot spread
                S_DIFF: begin
                    if (!wait_reg && kden <= 0) begin
                        status_reg <= STS_ZERO_DIV;
                        state_reg  <= S_OUT;
                    end else if (div_done) begin
                        wait_reg <= 1'b0;
                        d_reg[comp_reg][j_reg] <= clamp_hlim(div_quo);
                        if (comp_reg != 2'd2) begin
                            comp_reg <= comp_reg + 2'd1;
                        end else begin
                            comp_reg <= 2'd0;
                            if (j_reg == JW'(DEGREE)) begin
                                j_reg <= JW'(DEGREE);
                                k_reg <= JW'(1);
                                // degree one has no derivative blending pass
                                phase_reg <= (DEGREE < 2);
                                state_reg <= S_RAT;
                            end else begin
                                j_reg <= j_reg + JW'(1);
                            end
                        end
                    end
                end
                // blend ratio t for the current knot pair
                S_RAT: begin
                    if (!wait_reg && kden <= 0) begin
                        status_reg <= STS_ZERO_DIV;
                        state_reg  <= S_OUT;
                    end else if (div_done) begin
                        wait_reg  <= 1'b0;
                        t_reg     <= div_quo[KNOT_W-1:0];
                        comp_reg  <= 2'd0;
                        state_reg <= S_BLEND;
                    end
                end
                S_BLEND: begin
                    if (mul_done) begin
                        wait_reg <= 1'b0;
                        if (phase_reg) begin
                            h_reg[comp_reg][j_reg] <= blend_val;
                        end else begin
                            d_reg[comp_reg][j_reg] <= blend_val;
                        end
                        if (comp_reg != 2'd2) begin
                            comp_reg <= comp_reg + 2'd1;
                        end else begin
                            comp_reg  <= 2'd0;
                            state_reg <= S_ADV;
                        end
                    end
                end
                // advance j downward, then k, then from derivative to point pass
                S_ADV: begin
                    if (j_reg == j_low) begin
                        j_reg <= JW'(DEGREE);
                        if (k_reg == k_max) begin
                            k_reg <= JW'(1);
                            if (phase_reg) begin
                                state_reg <= S_FCHK;
                            end else begin
                                phase_reg <= 1'b1;
                                state_reg <= S_RAT;
                            end
                        end else begin
                            k_reg     <= k_reg + JW'(1);
                            state_reg <= S_RAT;
                        end
                    end else begin
                        j_reg     <= j_prev;
                        state_reg <= S_RAT;
                    end
                end
                S_FCHK: begin
                    comp_reg <= 2'd0;
                    if (w_val <= 0) begin
                        status_reg <= STS_ZERO_DIV;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg <= S_FDIV;
                    end
                end
                // point = P / W
                S_FDIV: begin
                    if (div_done) begin
                        wait_reg            <= 1'b0;
                        r_reg[comp_reg[0]]  <= sat32(div_quo);
                        state_reg           <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    if (mul_done) begin
                        wait_reg  <= 1'b0;
                        tmp_reg   <= mul_prod;
                        state_reg <= S_FSDIV;
                    end
                end
                // slope = (dP - dW * point) / W
                S_FSDIV: begin
                    if (div_done) begin
                        wait_reg                <= 1'b0;
                        slope_reg[comp_reg[0]]  <= sat32(div_quo);
                        state_reg               <= S_GMUL;
                    end
                end
                // advance tool position by slope times gain
                S_GMUL: begin
                    if (mul_done) begin
                        wait_reg <= 1'b0;
                        pos_reg[comp_reg[0]] <= sat32(ACC_W'(pos_reg[comp_reg[0]])
                                                      + (mul_prod >>> GAIN_W));
                        if (comp_reg == 2'd0) begin
                            comp_reg  <= 2'd1;
                            state_reg <= S_FDIV;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_RD0: begin
                    state_reg <= S_ST0;
                end
                S_ST0: begin
                    pos_reg[0] <= point_rdata.x;
                    pos_reg[1] <= point_rdata.y;
                    state_reg  <= S_OUT;
                end
                // hold until the result register is free
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_curve_x_reg <= r_reg[0];
                        m_curve_y_reg <= r_reg[1];
                        m_slope_x_reg <= slope_reg[0];
                        m_slope_y_reg <= slope_reg[1];
                        m_tool_x_reg  <= pos_reg[0];
                        m_tool_y_reg  <= pos_reg[1];
                        m_status_reg  <= status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_curve_x = m_curve_x_reg;
    assign m_curve_y = m_curve_y_reg;
    assign m_slope_x = m_slope_x_reg;
    assign m_slope_y = m_slope_y_reg;
    assign m_tool_x  = m_tool_x_reg;
    assign m_tool_y  = m_tool_y_reg;
    assign m_status  = m_status_reg;

endmodule
